// ===== rtl/trp_pkg.sv =====
// Shared types and constants of the torus route path unit.
package trp_pkg;

  localparam int NodeW      = 11;
  localparam int RowsRegW   = 6;
  localparam int ColsRegW   = 7;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 7;
  // Coordinate and dimension widths cover the largest supported grid.
  localparam int RowW       = 6;
  localparam int ColW       = 7;
  localparam int TotalW     = 12;
  localparam int MaxRowsDef = 32;
  localparam int MaxColsDef = 64;
  localparam int CmdDepth   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGridRows = 2'd0,
    CfgGridCols = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FrIdle,
    FrDiv,
    FrPush
  } front_state_e;

  typedef struct packed {
    logic [RowW-1:0]   rows;
    logic [ColW-1:0]   cols;
    logic [TotalW-1:0] total;
    logic [NodeW-1:0]  last_base;
  } geom_t;

  typedef struct packed {
    logic             bad;
    logic [NodeW-1:0] src;
    logic [RowW-1:0]  sr;
    logic [ColW-1:0]  sc;
    logic             pos_c;
    logic [ColW-1:0]  steps_c;
    logic             pos_r;
    logic [RowW-1:0]  steps_r;
  } route_cmd_t;

endpackage

// ===== rtl/trp_in_if.sv =====
// Input channel: source and destination node of one route request.
interface trp_in_if;
  logic                       valid;
  logic                       ready;
  logic [trp_pkg::NodeW-1:0]  source_node;
  logic [trp_pkg::NodeW-1:0]  dest_node;

  modport source(output valid, output source_node, output dest_node, input ready);
  modport sink(input valid, input source_node, input dest_node, output ready);
endinterface

// ===== rtl/trp_out_if.sv =====
// Output channel: one node of the hop path with its flags.
interface trp_out_if;
  logic                       valid;
  logic                       ready;
  logic [trp_pkg::NodeW-1:0]  hop_node;
  logic                       last_hop;
  logic                       bad_node;

  modport source(output valid, output hop_node, output last_hop, output bad_node,
                 input ready);
  modport sink(input valid, input hop_node, input last_hop, input bad_node,
               output ready);
endinterface

// ===== rtl/trp_front.sv =====
// Front end: takes a request, checks it and splits both nodes into row and column.
module trp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  trp_in_if.sink              in_i,
  input  trp_pkg::geom_t      geom_i,
  output trp_pkg::route_cmd_t cmd_o,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i
);

  localparam int CntW = $clog2(trp_pkg::NodeW + 1);

  trp_pkg::front_state_e state_q, state_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [trp_pkg::NodeW-1:0] src_q, squo_q, dquo_q;
  logic [trp_pkg::ColW-1:0]  srem_q, drem_q;
  logic                      bad_q;

  logic                      accept;
  logic                      bad_in;
  logic                      div_done;
  logic [trp_pkg::ColW:0]    cols_ext;
  logic [trp_pkg::ColW:0]    s_trial, d_trial;
  logic                      s_ge, d_ge;
  logic [trp_pkg::ColW-1:0]  s_rem_nx, d_rem_nx;

  logic [trp_pkg::RowW-1:0]  sr, dr, fwd_r, bwd_r;
  logic [trp_pkg::ColW-1:0]  sc, dc, fwd_c, bwd_c;

  assign accept   = in_i.valid && in_i.ready;
  assign bad_in   = ({1'b0, in_i.source_node} >= geom_i.total) ||
                    ({1'b0, in_i.dest_node} >= geom_i.total);
  assign div_done = (cnt_q == CntW'(trp_pkg::NodeW - 1));

  // Restoring division by the column count, one quotient bit per cycle.
  assign cols_ext = {1'b0, geom_i.cols};
  assign s_trial  = {srem_q, squo_q[trp_pkg::NodeW-1]};
  assign d_trial  = {drem_q, dquo_q[trp_pkg::NodeW-1]};
  assign s_ge     = (s_trial >= cols_ext);
  assign d_ge     = (d_trial >= cols_ext);
  assign s_rem_nx = s_ge ? trp_pkg::ColW'(s_trial - cols_ext) : trp_pkg::ColW'(s_trial);
  assign d_rem_nx = d_ge ? trp_pkg::ColW'(d_trial - cols_ext) : trp_pkg::ColW'(d_trial);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      trp_pkg::FrIdle: begin
        cnt_d = '0;
        if (in_i.valid) begin
          state_d = bad_in ? trp_pkg::FrPush : trp_pkg::FrDiv;
        end
      end
      trp_pkg::FrDiv: begin
        cnt_d = cnt_q + CntW'(1);
        if (div_done) begin
          state_d = trp_pkg::FrPush;
        end
      end
      trp_pkg::FrPush: begin
        if (cmd_ready_i) begin
          state_d = trp_pkg::FrIdle;
        end
      end
      default: state_d = trp_pkg::FrIdle;
    endcase
  end

  always_comb begin
    in_i.ready  = 1'b0;
    cmd_valid_o = 1'b0;
    case (state_q)
      trp_pkg::FrIdle: in_i.ready  = 1'b1;
      trp_pkg::FrPush: cmd_valid_o = 1'b1;
      default: begin
        in_i.ready  = 1'b0;
        cmd_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trp_pkg::FrIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q  <= in_i.source_node;
      squo_q <= in_i.source_node;
      dquo_q <= in_i.dest_node;
      srem_q <= '0;
      drem_q <= '0;
      bad_q  <= bad_in;
    end else if (state_q == trp_pkg::FrDiv) begin
      squo_q <= {squo_q[trp_pkg::NodeW-2:0], s_ge};
      dquo_q <= {dquo_q[trp_pkg::NodeW-2:0], d_ge};
      srem_q <= s_rem_nx;
      drem_q <= d_rem_nx;
    end
  end

  // Shorter direction per axis; a tie goes the positive way.
  assign sr = squo_q[trp_pkg::RowW-1:0];
  assign dr = dquo_q[trp_pkg::RowW-1:0];
  assign sc = srem_q;
  assign dc = drem_q;

  assign fwd_c = (dc >= sc) ? trp_pkg::ColW'(dc - sc)
               : trp_pkg::ColW'({1'b0, dc} + {1'b0, geom_i.cols} - {1'b0, sc});
  assign bwd_c = (sc >= dc) ? trp_pkg::ColW'(sc - dc)
               : trp_pkg::ColW'({1'b0, sc} + {1'b0, geom_i.cols} - {1'b0, dc});
  assign fwd_r = (dr >= sr) ? trp_pkg::RowW'(dr - sr)
               : trp_pkg::RowW'({1'b0, dr} + {1'b0, geom_i.rows} - {1'b0, sr});
  assign bwd_r = (sr >= dr) ? trp_pkg::RowW'(sr - dr)
               : trp_pkg::RowW'({1'b0, sr} + {1'b0, geom_i.rows} - {1'b0, dr});

  always_comb begin
    cmd_o.bad     = bad_q;
    cmd_o.src     = src_q;
    cmd_o.sr      = sr;
    cmd_o.sc      = sc;
    cmd_o.pos_c   = (fwd_c <= bwd_c);
    cmd_o.steps_c = (fwd_c <= bwd_c) ? fwd_c : bwd_c;
    cmd_o.pos_r   = (fwd_r <= bwd_r);
    cmd_o.steps_r = (fwd_r <= bwd_r) ? fwd_r : bwd_r;
  end

endmodule

// ===== rtl/trp_cmd_fifo.sv =====
// Short queue of route commands between the front end and the path walker.
module trp_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trp_pkg::route_cmd_t wr_cmd_i,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  output trp_pkg::route_cmd_t rd_cmd_o,
  output logic                rd_valid_o,
  input  logic                rd_ready_i
);

  localparam int PtrW = (trp_pkg::CmdDepth > 1) ? $clog2(trp_pkg::CmdDepth) : 1;
  localparam int CntW = $clog2(trp_pkg::CmdDepth + 1);

  trp_pkg::route_cmd_t mem_q [trp_pkg::CmdDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign wr_ready_o = (cnt_q != CntW'(trp_pkg::CmdDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_cmd_o   = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(trp_pkg::CmdDepth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(trp_pkg::CmdDepth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_cmd_i;
    end
  end

endmodule

// ===== rtl/trp_back.sv =====
// Back end: walks the path of one command and sends one node per item.
module trp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trp_pkg::route_cmd_t cmd_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  trp_pkg::geom_t      geom_i,
  trp_out_if.source           out_o
);

  logic                      out_valid_q, out_valid_d;
  logic                      walking_q, walking_d;
  logic [trp_pkg::NodeW-1:0] node_q, node_d;
  logic                      last_q, last_d;
  logic                      bad_q, bad_d;
  logic [trp_pkg::ColW-1:0]  cc_q, cc_d, steps_c_q, steps_c_d;
  logic [trp_pkg::RowW-1:0]  cr_q, cr_d, steps_r_q, steps_r_d;
  logic                      pos_c_q, pos_c_d, pos_r_q, pos_r_d;
  logic                      advance;
  logic                      last_step;

  // The output register refills whenever it is empty or being taken.
  assign advance     = !out_valid_q || out_o.ready;
  assign cmd_ready_o = advance && !walking_q;

  assign out_o.valid    = out_valid_q;
  assign out_o.hop_node = node_q;
  assign out_o.last_hop = last_q;
  assign out_o.bad_node = bad_q;

  always_comb begin
    out_valid_d = out_valid_q;
    walking_d   = walking_q;
    node_d      = node_q;
    last_d      = last_q;
    bad_d       = bad_q;
    cc_d        = cc_q;
    cr_d        = cr_q;
    steps_c_d   = steps_c_q;
    steps_r_d   = steps_r_q;
    pos_c_d     = pos_c_q;
    pos_r_d     = pos_r_q;
    last_step   = 1'b0;
    if (advance) begin
      if (walking_q) begin
        out_valid_d = 1'b1;
        if (steps_c_q != '0) begin
          // Column moves come first.
          steps_c_d = steps_c_q - trp_pkg::ColW'(1);
          last_step = (steps_c_q == trp_pkg::ColW'(1)) && (steps_r_q == '0);
          if (pos_c_q) begin
            if (trp_pkg::ColW'(cc_q + trp_pkg::ColW'(1)) == geom_i.cols) begin
              cc_d   = '0;
              node_d = node_q - trp_pkg::NodeW'(geom_i.cols) + trp_pkg::NodeW'(1);
            end else begin
              cc_d   = cc_q + trp_pkg::ColW'(1);
              node_d = node_q + trp_pkg::NodeW'(1);
            end
          end else begin
            if (cc_q == '0) begin
              cc_d   = geom_i.cols - trp_pkg::ColW'(1);
              node_d = node_q + trp_pkg::NodeW'(geom_i.cols) - trp_pkg::NodeW'(1);
            end else begin
              cc_d   = cc_q - trp_pkg::ColW'(1);
              node_d = node_q - trp_pkg::NodeW'(1);
            end
          end
        end else begin
          steps_r_d = steps_r_q - trp_pkg::RowW'(1);
          last_step = (steps_r_q == trp_pkg::RowW'(1));
          if (pos_r_q) begin
            if (trp_pkg::RowW'(cr_q + trp_pkg::RowW'(1)) == geom_i.rows) begin
              cr_d   = '0;
              node_d = trp_pkg::NodeW'(cc_q);
            end else begin
              cr_d   = cr_q + trp_pkg::RowW'(1);
              node_d = node_q + trp_pkg::NodeW'(geom_i.cols);
            end
          end else begin
            if (cr_q == '0) begin
              cr_d   = geom_i.rows - trp_pkg::RowW'(1);
              node_d = geom_i.last_base + trp_pkg::NodeW'(cc_q);
            end else begin
              cr_d   = cr_q - trp_pkg::RowW'(1);
              node_d = node_q - trp_pkg::NodeW'(geom_i.cols);
            end
          end
        end
        last_d    = last_step;
        walking_d = !last_step;
      end else if (cmd_valid_i) begin
        // The first node of a path is the source itself.
        out_valid_d = 1'b1;
        last_step   = cmd_i.bad || ((cmd_i.steps_c == '0) && (cmd_i.steps_r == '0));
        node_d      = cmd_i.bad ? '0 : cmd_i.src;
        last_d      = last_step;
        bad_d       = cmd_i.bad;
        walking_d   = !last_step;
        cc_d        = cmd_i.sc;
        cr_d        = cmd_i.sr;
        steps_c_d   = cmd_i.steps_c;
        steps_r_d   = cmd_i.steps_r;
        pos_c_d     = cmd_i.pos_c;
        pos_r_d     = cmd_i.pos_r;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      walking_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      walking_q   <= walking_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q    <= node_d;
    last_q    <= last_d;
    bad_q     <= bad_d;
    cc_q      <= cc_d;
    cr_q      <= cr_d;
    steps_c_q <= steps_c_d;
    steps_r_q <= steps_r_d;
    pos_c_q   <= pos_c_d;
    pos_r_q   <= pos_r_d;
  end

endmodule

// ===== rtl/torus_xy_route_path_unit.sv =====
// Top level of the torus XY route path unit: registers, front end, queue, walker.
//
// Each item on in_i carries a source and a destination node, numbered row-major on
// a grid_rows by grid_cols torus. For each item the unit sends the hop path on
// out_o, one node per item: the source first, then the column moves along the
// shorter wraparound direction, then the row moves; last_hop marks the
// destination. A node outside the grid gives a single item with bad_node and
// last_hop set and hop_node zero.
// The front end takes one request at a time: a valid request is accepted, runs
// 11 steps of the bit-serial row/column division and is handed off; a bad one
// skips the division. A two-entry command queue lets it work on the next
// request while the walker still sends the previous path.
// The walker sends one node per cycle while the receiver is ready; a path has up
// to 49 nodes on a 32 by 64 grid. When the receiver holds ready low, the current
// node stays in the output register and the walker waits; the front end and
// queue fill and then stall. Reset empties the pipeline and sets both grid
// dimensions to 1. The user must make configuration writes on cfg_we_i /
// cfg_idx_i / cfg_data_i only while the unit is idle; the unit itself does
// not enforce this.
module torus_xy_route_path_unit #(
  parameter int MAX_ROWS = trp_pkg::MaxRowsDef,
  parameter int MAX_COLS = trp_pkg::MaxColsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  trp_in_if.sink                       in_i,
  trp_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [trp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [trp_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [trp_pkg::RowW-1:0]   rows_q, rows_d;
  logic [trp_pkg::ColW-1:0]   cols_q, cols_d;
  logic [trp_pkg::TotalW-1:0] total_q, last_base_q;
  logic [trp_pkg::TotalW-1:0] rows_ext, cols_ext;
  logic [trp_pkg::RowsRegW-1:0] raw_rows;
  logic [trp_pkg::ColsRegW-1:0] raw_cols;
  logic [trp_pkg::RowW-1:0]   rows_clamped;
  logic [trp_pkg::ColW-1:0]   cols_clamped;
  trp_pkg::geom_t             geom;

  trp_pkg::route_cmd_t        front_cmd, back_cmd;
  logic                       front_valid, front_ready;
  logic                       back_valid, back_ready;

  assign raw_rows = cfg_data_i[trp_pkg::RowsRegW-1:0];
  assign raw_cols = cfg_data_i[trp_pkg::ColsRegW-1:0];

  // A dimension of zero means one; larger values saturate at the grid bound.
  always_comb begin
    if (raw_rows == '0) begin
      rows_clamped = trp_pkg::RowW'(1);
    end else if (int'(raw_rows) > MAX_ROWS) begin
      rows_clamped = trp_pkg::RowW'(MAX_ROWS);
    end else begin
      rows_clamped = trp_pkg::RowW'(raw_rows);
    end
    if (raw_cols == '0) begin
      cols_clamped = trp_pkg::ColW'(1);
    end else if (int'(raw_cols) > MAX_COLS) begin
      cols_clamped = trp_pkg::ColW'(MAX_COLS);
    end else begin
      cols_clamped = trp_pkg::ColW'(raw_cols);
    end
  end

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        trp_pkg::CfgGridRows: rows_d = rows_clamped;
        trp_pkg::CfgGridCols: cols_d = cols_clamped;
        default: begin
          rows_d = rows_q;
          cols_d = cols_q;
        end
      endcase
    end
  end

  assign rows_ext = trp_pkg::TotalW'(rows_q);
  assign cols_ext = trp_pkg::TotalW'(cols_q);

  // Grid size and the base of the last row follow the dimensions in the next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= trp_pkg::RowW'(1);
      cols_q      <= trp_pkg::ColW'(1);
      total_q     <= trp_pkg::TotalW'(1);
      last_base_q <= '0;
    end else begin
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      total_q     <= rows_ext * cols_ext;
      last_base_q <= (rows_ext - trp_pkg::TotalW'(1)) * cols_ext;
    end
  end

  always_comb begin
    geom.rows      = rows_q;
    geom.cols      = cols_q;
    geom.total     = total_q;
    geom.last_base = last_base_q[trp_pkg::NodeW-1:0];
  end

  trp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .geom_i      (geom),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  trp_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cmd_i   (front_cmd),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .rd_cmd_o   (back_cmd),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready)
  );

  trp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .geom_i      (geom),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.bad_node) |-> out_o.last_hop)
    else $error("bad-node item not marked as last");

  a_bad_node_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.bad_node) |-> (out_o.hop_node == '0))
    else $error("bad-node item carries a nonzero node");

  a_path_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last_hop) |=> out_o.valid)
    else $error("path output broke off before its last node");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("front end took a second request while busy");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the torus XY route path unit.
`timescale 1ns / 1ps

module tb;
  import trp_pkg::*;

  localparam int unsigned ClkHalf       = 6;
  localparam int unsigned ClkPeriod     = 2 * ClkHalf;
  localparam int unsigned TimeoutCycles = 1000000;
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned LongHold      = 400;

  // Indexes past the end of the register map; writes there must change nothing.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef struct {
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] dst;
  } route_req_t;

  typedef struct {
    logic [NodeW-1:0] node;
    logic             is_last;
    logic             is_bad;
  } hop_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  trp_in_if  in_ch ();
  trp_out_if out_ch ();

  torus_xy_route_path_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #(ClkHalf) clk_i = 1'b1;
    #(ClkHalf) clk_i = 1'b0;
  end

  route_req_t       route_reqs[$];
  hop_t             hop_expect[$];
  logic [RowsRegW-1:0] rows_raw = 1;
  logic [ColsRegW-1:0] cols_raw = 1;
  int unsigned      idle_odds = 0;
  int unsigned      err_cnt = 0;
  logic             hold_req = 1'b0;
  int unsigned      hold_left;
  logic [4:0]       send_gap;
  logic [4:0]       recv_gap;

  function automatic int unsigned dim_clip(int unsigned v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int unsigned grid_nodes();
    return dim_clip(32'(rows_raw), MaxRowsDef) * dim_clip(32'(cols_raw), MaxColsDef);
  endfunction

  // Appends one expected node at the tail of the expected results.
  function automatic void add_hop(input logic [NodeW-1:0] node_v, input logic last_v,
                                  input logic bad_v);
    hop_t h;
    h.node    = node_v;
    h.is_last = last_v;
    h.is_bad  = bad_v;
    hop_expect.insert(hop_expect.size(), h);
  endfunction

  // Appends the whole hop path of one request to the expected results.
  function automatic void route_predict(input logic [NodeW-1:0] src,
                                        input logic [NodeW-1:0] dst);
    int unsigned rows, cols, sr, sc, dr, dc, cr, cc, fwd, bwd, steps_c, steps_r;
    bit pos_c, pos_r;
    rows = dim_clip(32'(rows_raw), MaxRowsDef);
    cols = dim_clip(32'(cols_raw), MaxColsDef);
    if (src >= rows * cols || dst >= rows * cols) begin
      add_hop('0, 1'b1, 1'b1);
      return;
    end
    sr = src / cols;
    sc = src % cols;
    dr = dst / cols;
    dc = dst % cols;

    fwd     = (dc >= sc) ? dc - sc : dc + cols - sc;
    bwd     = (sc >= dc) ? sc - dc : sc + cols - dc;
    pos_c   = (fwd <= bwd);
    steps_c = pos_c ? fwd : bwd;

    fwd     = (dr >= sr) ? dr - sr : dr + rows - sr;
    bwd     = (sr >= dr) ? sr - dr : sr + rows - dr;
    pos_r   = (fwd <= bwd);
    steps_r = pos_r ? fwd : bwd;

    cr = sr;
    cc = sc;
    add_hop(src, (steps_c == 0 && steps_r == 0), 1'b0);
    for (int unsigned i = 0; i < steps_c; i++) begin
      if (pos_c) cc = (cc + 1 == cols) ? 0 : cc + 1;
      else       cc = (cc == 0) ? cols - 1 : cc - 1;
      add_hop(NodeW'(cr * cols + cc), (i + 1 == steps_c && steps_r == 0), 1'b0);
    end
    for (int unsigned i = 0; i < steps_r; i++) begin
      if (pos_r) cr = (cr + 1 == rows) ? 0 : cr + 1;
      else       cr = (cr == 0) ? rows - 1 : cr - 1;
      add_hop(NodeW'(cr * cols + cc), (i + 1 == steps_r), 1'b0);
    end
  endfunction

  // Request driver: predicts each accepted item and presents the next one.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    route_req_t nxt;
    if (!rst_ni) begin
      in_ch.valid       <= 1'b0;
      in_ch.source_node <= '0;
      in_ch.dest_node   <= '0;
      send_gap          <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        route_predict(in_ch.source_node, in_ch.dest_node);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0) begin
          send_gap    <= send_gap - 5'd1;
          in_ch.valid <= 1'b0;
        end else if (route_reqs.size() != 0) begin
          nxt = route_reqs.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.source_node <= nxt.src;
          in_ch.dest_node   <= nxt.dst;
          if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            send_gap <= 5'($urandom_range(1, 18));
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by a one-cycle request from the stimulus.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= LongHold;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: compares each accepted node with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    hop_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (hop_expect.size() == 0) begin
          $display("%0t: unexpected hop: expected none, actual node %0d last %0b bad %0b",
                   $time, out_ch.hop_node, out_ch.last_hop, out_ch.bad_node);
          err_cnt++;
        end else begin
          want = hop_expect.pop_front();
          if (out_ch.hop_node !== want.node) begin
            $display("%0t: hop_node mismatch: expected %0d, actual %0d",
                     $time, want.node, out_ch.hop_node);
            err_cnt++;
          end
          if (out_ch.last_hop !== want.is_last) begin
            $display("%0t: last_hop mismatch: expected %0b, actual %0b",
                     $time, want.is_last, out_ch.last_hop);
            err_cnt++;
          end
          if (out_ch.bad_node !== want.is_bad) begin
            $display("%0t: bad_node mismatch: expected %0b, actual %0b",
                     $time, want.is_bad, out_ch.bad_node);
            err_cnt++;
          end
        end
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap     <= recv_gap - 5'd1;
        out_ch.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        recv_gap     <= 5'($urandom_range(0, 17));
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgGridRows) rows_raw = data[RowsRegW-1:0];
    else if (idx == CfgGridCols) cols_raw = data;
  endtask

  task automatic set_grid(input logic [CfgDataW-1:0] rows, input logic [CfgDataW-1:0] cols);
    cfg_write(CfgGridRows, rows);
    cfg_write(CfgGridCols, cols);
  endtask

  task automatic queue_route(input int unsigned src, input int unsigned dst);
    route_req_t req;
    req.src = NodeW'(src);
    req.dst = NodeW'(dst);
    route_reqs.insert(route_reqs.size(), req);
  endtask

  // Mostly routes inside the grid, with some arbitrary node numbers mixed in.
  task automatic queue_random_routes(input int unsigned count);
    int unsigned top;
    top = grid_nodes() - 1;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) queue_route($urandom_range(0, top), $urandom_range(0, top));
      else queue_route($urandom_range(0, 2047), $urandom_range(0, 2047));
    end
  endtask

  // Waits until every request is taken and every hop has come back, then lets the
  // front end run dry before the grid may change.
  task automatic settle();
    @(negedge clk_i);
    while (route_reqs.size() != 0 || in_ch.valid || hop_expect.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CfgGridRows;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset grid is a single node: only node 0 is valid.
    idle_odds = 4;
    queue_route(0, 0);
    queue_route(1, 0);
    queue_route(0, 2047);
    queue_route(2047, 2047);
    settle();

    // Largest grid: corners, ties in both axes, wraparound backwards.
    set_grid(32, 64);
    @(negedge clk_i);
    queue_route(0, 2047);
    queue_route(2047, 0);
    queue_route(0, 32);
    queue_route(0, 1024);
    queue_route(0, 1056);
    queue_route(33, 33);
    queue_route(0, 63);
    queue_route(1024, 0);
    queue_route(1365, 682);
    settle();

    // Rows write drops the top data bit and saturates; zero columns acts as one.
    set_grid(7'h7F, 0);
    @(negedge clk_i);
    queue_route(31, 0);
    queue_route(0, 16);
    queue_route(5, 20);
    queue_route(32, 0);
    settle();

    // Zero rows acts as one; columns above the bound saturate.
    set_grid(0, 127);
    @(negedge clk_i);
    queue_route(0, 63);
    queue_route(63, 0);
    queue_route(10, 42);
    queue_route(64, 0);
    settle();

    // Odd grid; writes to unused indexes must leave it alone.
    set_grid(5, 3);
    cfg_write(CfgSpareA, 9);
    cfg_write(CfgSpareB, 1);
    @(negedge clk_i);
    queue_route(0, 14);
    queue_route(14, 0);
    queue_route(7, 7);
    queue_route(15, 3);
    queue_route(3, 15);
    queue_route(4, 11);
    settle();

    // Full grid with a long output stall while requests keep coming.
    set_grid(32, 64);
    @(negedge clk_i);
    idle_odds = 3;
    queue_random_routes(22);
    hold_req = 1'b1;
    @(negedge clk_i);
    hold_req = 1'b0;
    settle();

    // Random grid, with the sender pausing halfway for a full drain.
    set_grid(7'($urandom_range(1, 32)), 7'($urandom_range(1, 64)));
    @(negedge clk_i);
    idle_odds = 6;
    queue_random_routes(11);
    settle();
    queue_random_routes(11);
    settle();

    // Single column: paths run along rows only.
    set_grid(32, 1);
    @(negedge clk_i);
    idle_odds = 2;
    queue_random_routes(22);
    settle();

    // Raw register values, zero and saturating included.
    set_grid(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    @(negedge clk_i);
    idle_odds = 8;
    queue_random_routes(22);
    settle();

    // Single row: paths run along columns only.
    set_grid(1, 64);
    @(negedge clk_i);
    idle_odds = 4;
    queue_random_routes(22);
    settle();

    // Closing stretch at full rate on both sides.
    set_grid(32, 64);
    @(negedge clk_i);
    idle_odds = 0;
    queue_random_routes(22);
    settle();

    if (err_cnt == 0 && hop_expect.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("%0t: timeout", $time);
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/trp_pkg.sv
rtl/trp_in_if.sv
rtl/trp_out_if.sv
rtl/trp_front.sv
rtl/trp_cmd_fifo.sv
rtl/trp_back.sv
rtl/torus_xy_route_path_unit.sv
tb/tb.sv
